@@ rtl/pbpa_pkg.sv @@
package pbpa_pkg;

   // pool geometry
   localparam int NUM_PAGES  = 16;
   localparam int MAX_SLOTS  = 32;
   localparam int PAGE_W     = $clog2(NUM_PAGES);
   localparam int IDX_W      = $clog2(MAX_SLOTS);
   localparam int SLOT_CNT_W = IDX_W + 1;
   localparam int COUNT_W    = 10;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;
   localparam int BPP_W      = 6;
   localparam int LIMIT_W    = 10;

   localparam logic [BPP_W-1:0]   BPP_RESET   = 6'd2;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUFFERS_PER_PAGE = 1'b0,
      CSR_CACHE_LIMIT      = 1'b1
   } csr_index_type;

   typedef enum logic {
      ACTION_ALLOC = 1'b0,
      ACTION_FREE  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_PAGE  = 2'd1,
      STATUS_BAD_FREE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      LIST_IDLE   = 2'd0,
      LIST_PUSH   = 2'd1,
      LIST_REMOVE = 2'd2
   } list_op_type;

   typedef struct packed {
      list_op_type         op;
      logic [PAGE_W-1:0]   page;
   } list_cmd_type;

   typedef struct packed {
      action_type          action;
      logic [PAGE_W-1:0]   page_slot;
      logic [IDX_W-1:0]    buffer_index;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [PAGE_W-1:0]   out_page_slot;
      logic [IDX_W-1:0]    out_buffer_index;
      logic                page_released;
      logic [COUNT_W-1:0]  free_buffers;
   } rsp_type;

endpackage

@@ rtl/pbpa_list.sv @@
// recency list of partly free pages, newest at entry 0
module pbpa_list (
   input  logic                          clock,
   input  logic                          reset,
   input  pbpa_pkg::list_cmd_type        cmd,
   output logic                          head_valid,
   output logic [pbpa_pkg::PAGE_W-1:0]   head_page
);

   localparam int N = pbpa_pkg::NUM_PAGES;

   logic [pbpa_pkg::PAGE_W-1:0] ent_ff [N];
   logic [pbpa_pkg::PAGE_W-1:0] ent_in [N];
   logic [N-1:0]                vld_ff;
   logic [N-1:0]                vld_in;
   logic [N-1:0]                match;
   logic [N-1:0]                above;

   assign head_valid = vld_ff[0];
   assign head_page  = ent_ff[0];

   always_comb begin
      for (int i = 0; i < N; i++) begin
         match[i] = vld_ff[i] && (ent_ff[i] == cmd.page);
      end
      // entries at or behind the removed one move up
      for (int i = 0; i < N; i++) begin
         above[i] = 1'b0;
         for (int j = 0; j < N; j++) begin
            if (j <= i && match[j]) begin
               above[i] = 1'b1;
            end
         end
      end
      for (int i = 0; i < N; i++) begin
         ent_in[i] = ent_ff[i];
      end
      vld_in = vld_ff;
      case (cmd.op)
         pbpa_pkg::LIST_PUSH: begin
            ent_in[0] = cmd.page;
            vld_in[0] = 1'b1;
            for (int i = 1; i < N; i++) begin
               ent_in[i] = ent_ff[i-1];
               vld_in[i] = vld_ff[i-1];
            end
         end
         pbpa_pkg::LIST_REMOVE: begin
            for (int i = 0; i < N - 1; i++) begin
               if (above[i]) begin
                  ent_in[i] = ent_ff[i+1];
                  vld_in[i] = vld_ff[i+1];
               end
            end
            if (above[N-1]) begin
               vld_in[N-1] = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         ent_ff[i] <= ent_in[i];
      end
   end

endmodule

@@ rtl/pbpa_engine.sv @@
// page store, free count and per-transaction decision
module pbpa_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  pbpa_pkg::req_type             req,
   input  logic [pbpa_pkg::BPP_W-1:0]    bpp,
   input  logic [pbpa_pkg::LIMIT_W-1:0]  cache_limit,
   output pbpa_pkg::rsp_type             rsp
);

   localparam int N  = pbpa_pkg::NUM_PAGES;
   localparam int S  = pbpa_pkg::MAX_SLOTS;
   localparam int PW = pbpa_pkg::PAGE_W;
   localparam int IW = pbpa_pkg::IDX_W;
   localparam int SW = pbpa_pkg::SLOT_CNT_W;
   localparam int CW = pbpa_pkg::COUNT_W;

   logic [S-1:0]   mask_ff [N];
   logic [N-1:0]   mapped_ff;
   logic [N-1:0]   mapped_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;

   logic [SW-1:0]  slot_cnt;
   logic [S-1:0]   full_mask;
   logic [PW-1:0]  rd_page;
   logic [S-1:0]   rd_mask;
   logic [IW-1:0]  low_idx;
   logic [PW-1:0]  free_pg;
   logic           any_unmapped;
   logic [S-1:0]   bit_sel;
   logic [S-1:0]   new_mask;
   logic [CW:0]    count_inc;
   logic           bad_free;

   logic           wr_en;
   logic [PW-1:0]  wr_page;
   logic [S-1:0]   wr_mask;
   logic           map_set;
   logic           map_clr;

   pbpa_pkg::list_op_type  list_op;
   pbpa_pkg::list_cmd_type list_cmd;
   logic                   head_valid;
   logic [PW-1:0]          head_page;

   pbpa_list u_list (
      .clock      (clock),
      .reset      (reset),
      .cmd        (list_cmd),
      .head_valid (head_valid),
      .head_page  (head_page)
   );

   // slot count clamped to 1..MAX_SLOTS
   always_comb begin
      if (bpp == '0) begin
         slot_cnt = SW'(1);
      end else if ({1'b0, bpp} > (pbpa_pkg::BPP_W + 1)'(S)) begin
         slot_cnt = SW'(S);
      end else begin
         slot_cnt = SW'(bpp);
      end
      for (int k = 0; k < S; k++) begin
         full_mask[k] = (SW'(k) < slot_cnt);
      end
   end

   assign rd_page      = (req.action == pbpa_pkg::ACTION_FREE) ? req.page_slot : head_page;
   assign rd_mask      = mask_ff[rd_page];
   assign any_unmapped = ~&mapped_ff;
   assign bit_sel      = S'(1) << req.buffer_index;
   assign count_inc    = {1'b0, count_ff} + (CW + 1)'(1);

   // lowest free slot, top slot when the mask is empty
   always_comb begin
      low_idx = IW'(S - 1);
      for (int k = S - 1; k >= 0; k--) begin
         if (rd_mask[k]) begin
            low_idx = IW'(k);
         end
      end
   end

   // lowest unmapped page
   always_comb begin
      free_pg = '0;
      for (int k = N - 1; k >= 0; k--) begin
         if (!mapped_ff[k]) begin
            free_pg = PW'(k);
         end
      end
   end

   always_comb begin
      rsp.status           = pbpa_pkg::STATUS_OK;
      rsp.out_page_slot    = '0;
      rsp.out_buffer_index = '0;
      rsp.page_released    = 1'b0;
      new_mask  = rd_mask;
      bad_free  = 1'b0;
      wr_en     = 1'b0;
      wr_page   = rd_page;
      wr_mask   = rd_mask;
      map_set   = 1'b0;
      map_clr   = 1'b0;
      count_in  = count_ff;
      list_op   = pbpa_pkg::LIST_IDLE;
      if (req.action == pbpa_pkg::ACTION_ALLOC) begin
         if (head_valid) begin
            new_mask = rd_mask & ~(S'(1) << low_idx);
            wr_en    = 1'b1;
            wr_mask  = new_mask;
            if (count_ff != '0) begin
               count_in = count_ff - CW'(1);
            end
            if (new_mask == '0) begin
               list_op = pbpa_pkg::LIST_REMOVE;
            end
            rsp.out_page_slot    = head_page;
            rsp.out_buffer_index = low_idx;
         end else if (!any_unmapped) begin
            rsp.status = pbpa_pkg::STATUS_NO_PAGE;
         end else begin
            // fresh page, slot 0 handed out
            wr_en    = 1'b1;
            wr_page  = free_pg;
            wr_mask  = full_mask & ~S'(1);
            map_set  = 1'b1;
            count_in = count_ff + CW'(slot_cnt - SW'(1));
            if (slot_cnt != SW'(1)) begin
               list_op = pbpa_pkg::LIST_PUSH;
            end
            rsp.out_page_slot = free_pg;
         end
      end else begin
         bad_free = !mapped_ff[req.page_slot] || (SW'(req.buffer_index) >= slot_cnt) ||
                    ((rd_mask & bit_sel) != '0);
         if (bad_free) begin
            rsp.status = pbpa_pkg::STATUS_BAD_FREE;
         end else begin
            new_mask = rd_mask | bit_sel;
            wr_en    = 1'b1;
            if (count_inc > {1'b0, cache_limit} && new_mask == full_mask) begin
               // page wholly free beyond the cache limit: give it back
               if (rd_mask != '0) begin
                  list_op = pbpa_pkg::LIST_REMOVE;
               end
               count_in          = CW'(count_inc - (CW + 1)'(slot_cnt));
               wr_mask           = '0;
               map_clr           = 1'b1;
               rsp.page_released = 1'b1;
            end else begin
               wr_mask  = new_mask;
               count_in = count_inc[CW-1:0];
               if (rd_mask == '0) begin
                  list_op = pbpa_pkg::LIST_PUSH;
               end
            end
         end
      end
      rsp.free_buffers = count_in;
   end

   always_comb begin
      list_cmd.op   = advance ? list_op : pbpa_pkg::LIST_IDLE;
      list_cmd.page = wr_page;
      mapped_in     = mapped_ff;
      if (map_set) begin
         mapped_in[wr_page] = 1'b1;
      end
      if (map_clr) begin
         mapped_in[wr_page] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mapped_ff <= '0;
         count_ff  <= '0;
      end else if (advance) begin
         mapped_ff <= mapped_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && wr_en) begin
         mask_ff[wr_page] <= wr_mask;
      end
   end

endmodule

@@ rtl/paged_buffer_pool_allocator_top.sv @@
// paged buffer pool allocator: hands out and takes back packet buffer slots grouped into
// pages, each page tracked by a free-slot bitmap. an allocate transaction (tuser 0) takes the
// lowest free slot of the most recently listed partly free page, or maps the lowest unused
// page with slot 0 taken, and reports status 1 when no page is listed and every page is
// mapped. a free transaction (tuser 1) returns page_slot/buffer_index; freeing an unmapped
// page, a slot beyond buffers_per_page or a slot already free gives status 2 and changes
// nothing. a page that becomes wholly free while the free count exceeds cache_limit is
// released. every request gives exactly one response. one transaction per clock is sustained
// while rsp_tready stays high. an accepted request is held in the input register while the
// page-store read-modify-write and recency list update are worked out, and moves to the
// response register when that is empty or being drained. while a response waits, one more
// request is held in the input register and req_tready drops until the response is taken.
// configuration writes take effect at once and are meant for idle periods only.
module paged_buffer_pool_allocator_top (
   input  logic                               clock,
   input  logic                               reset,

   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,   // page_slot[3:0], buffer_index[8:4]
   input  logic [0:0]                         req_tuser,   // action

   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [23:0]                        rsp_tdata,   // out_page_slot[3:0],
                                                           // out_buffer_index[8:4],
                                                           // page_released[9],
                                                           // free_buffers[19:10]
   output logic [1:0]                         rsp_tuser,   // status

   // configuration writes
   input  logic                               csr_wr_en,
   input  logic [pbpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pbpa_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int PW = pbpa_pkg::PAGE_W;
   localparam int IW = pbpa_pkg::IDX_W;

   // configuration registers
   logic [pbpa_pkg::BPP_W-1:0]   bpp_ff;
   logic [pbpa_pkg::LIMIT_W-1:0] limit_ff;

   // input register
   pbpa_pkg::req_type  req_ff;
   pbpa_pkg::req_type  req_in;
   logic               in_vld_ff;
   logic               in_vld_in;

   // response register
   pbpa_pkg::rsp_type  rsp_ff;
   pbpa_pkg::rsp_type  rsp_in;
   logic               rsp_vld_ff;
   logic               rsp_vld_in;

   logic               advance;
   logic               req_take;

   // the held transaction moves on when the response register is empty or being drained
   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign req_in.action       = pbpa_pkg::action_type'(req_tuser[0]);
   assign req_in.page_slot    = req_tdata[PW-1:0];
   assign req_in.buffer_index = req_tdata[PW+IW-1:PW];

   assign in_vld_in  = req_take || (in_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff   <= pbpa_pkg::BPP_RESET;
         limit_ff <= pbpa_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (pbpa_pkg::csr_index_type'(csr_index))
            pbpa_pkg::CSR_BUFFERS_PER_PAGE: begin
               bpp_ff <= csr_wdata[pbpa_pkg::BPP_W-1:0];
            end
            pbpa_pkg::CSR_CACHE_LIMIT: begin
               limit_ff <= csr_wdata[pbpa_pkg::LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // decision and state update for the held transaction
   pbpa_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req         (req_ff),
      .bpp         (bpp_ff),
      .cache_limit (limit_ff),
      .rsp         (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {4'b0000, rsp_ff.free_buffers, rsp_ff.page_released,
                        rsp_ff.out_buffer_index, rsp_ff.out_page_slot};

   // a transaction leaving the input register always lands in the response register
   a_advance_fills_rsp : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("response register not loaded after advance");

   // an empty list means every mapped page is full, so no free buffers remain
   a_no_page_zero_free : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == pbpa_pkg::STATUS_NO_PAGE) |-> (rsp_tdata[19:10] == '0))
      else $error("pool exhausted with free buffers counted");

   // a rejected free neither releases a page nor reports a buffer
   a_bad_free_quiet : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == pbpa_pkg::STATUS_BAD_FREE) |-> (rsp_tdata[9:0] == '0))
      else $error("invalid free produced a page or release");

   // the input register never drops a held transaction
   a_hold_input : assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |=> (in_vld_ff && $stable(req_ff)))
      else $error("held transaction lost or changed");

endmodule

@@ verif/testbench.sv @@
module testbench;
   import pbpa_pkg::*;

   // run shape
   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 11;
   localparam int SEGMENTS      = 6;
   localparam int SEG_ITEMS     = 300;
   localparam int NOISE_PCT     = 8;      // share of fully random free requests
   localparam int HOLD_CYCLES   = 120;    // long response back-pressure stretch
   localparam int SETTLE_CYCLES = 8;      // settle wait after the drain
   localparam int QUIET_LIMIT   = 5000;   // cycles without any transaction
   localparam int SCRIPT_LEN    = 26;

   // directed script rows: an item, or a register write between items
   typedef enum logic [1:0] {
      DO_ALLOC     = 2'd0,
      DO_FREE      = 2'd1,
      DO_SET_SLOTS = 2'd2,
      DO_SET_LIMIT = 2'd3
   } step_kind_type;

   typedef struct packed {
      step_kind_type       kind;
      logic [9:0]          page_or_value;   // page_slot for a free, value for a write
      logic [IDX_W-1:0]    index;
      logic                typed;           // expected response written out below
      rsp_type             want;
   } script_row_type;

   localparam rsp_type NO_WANT = '0;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [15:0]             req_tdata = '0;     // page_slot[3:0], buffer_index[8:4]
   logic [0:0]              req_tuser = '0;     // action

   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [23:0]             rsp_tdata;          // out_page_slot[3:0], out_buffer_index[8:4],
                                                // page_released[9], free_buffers[19:10]
   logic [1:0]              rsp_tuser;          // status

   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // shadow of the pool: bitmaps, mapping, recency list, free count, registers
   logic [31:0]             page_bits [NUM_PAGES];
   logic                    page_live [NUM_PAGES];
   int                      link_next [NUM_PAGES];
   int                      link_prev [NUM_PAGES];
   int                      recent_head;
   int                      spare_count;
   int                      slots_cfg;
   int                      keep_limit;

   rsp_type                 due_responses [$];
   rsp_type                 head_want;
   int                      error_count = 0;

   // idling and back-pressure control, set per segment by the stimulus process
   int                      sender_idle_pct = 0;
   int                      receiver_idle_pct = 0;
   bit                      hold_ask = 1'b0;
   bit                      hold_done = 1'b0;
   int                      hold_left = 0;
   int                      quiet_cycles = 0;

   // directed part: empty-pool errors, first mappings, double frees, out-of-range
   // slots, release with zero cache limit, clamped slot counts (0 and 63),
   // single-slot pages, a slot count change with pages mapped, and field extremes
   script_row_type script_rows [SCRIPT_LEN] = '{
      '{DO_FREE,      10'd0,    5'd0,  1'b1, '{STATUS_BAD_FREE, 4'd0, 5'd0, 1'b0, 10'd0}},
      '{DO_ALLOC,     10'd0,    5'd0,  1'b1, '{STATUS_OK,       4'd0, 5'd0, 1'b0, 10'd1}},
      '{DO_ALLOC,     10'd0,    5'd0,  1'b1, '{STATUS_OK,       4'd0, 5'd1, 1'b0, 10'd0}},
      '{DO_ALLOC,     10'd0,    5'd0,  1'b1, '{STATUS_OK,       4'd1, 5'd0, 1'b0, 10'd1}},
      '{DO_FREE,      10'd0,    5'd1,  1'b0, NO_WANT},
      '{DO_FREE,      10'd0,    5'd1,  1'b1, '{STATUS_BAD_FREE, 4'd0, 5'd0, 1'b0, 10'd2}},
      '{DO_FREE,      10'd0,    5'd31, 1'b1, '{STATUS_BAD_FREE, 4'd0, 5'd0, 1'b0, 10'd2}},
      '{DO_FREE,      10'd15,   5'd0,  1'b1, '{STATUS_BAD_FREE, 4'd0, 5'd0, 1'b0, 10'd2}},
      '{DO_ALLOC,     10'd0,    5'd0,  1'b0, NO_WANT},
      '{DO_FREE,      10'd1,    5'd0,  1'b0, NO_WANT},
      '{DO_SET_LIMIT, 10'd0,    5'd0,  1'b0, NO_WANT},
      '{DO_FREE,      10'd0,    5'd0,  1'b0, NO_WANT},
      '{DO_FREE,      10'd0,    5'd1,  1'b0, NO_WANT},
      '{DO_SET_SLOTS, 10'd0,    5'd0,  1'b0, NO_WANT},
      '{DO_ALLOC,     10'd0,    5'd0,  1'b0, NO_WANT},
      '{DO_ALLOC,     10'd0,    5'd0,  1'b0, NO_WANT},
      '{DO_ALLOC,     10'd0,    5'd0,  1'b0, NO_WANT},
      '{DO_FREE,      10'd1,    5'd1,  1'b1, '{STATUS_BAD_FREE, 4'd0, 5'd0, 1'b0, 10'd0}},
      '{DO_FREE,      10'd1,    5'd0,  1'b0, NO_WANT},
      '{DO_SET_SLOTS, 10'd63,   5'd0,  1'b0, NO_WANT},
      '{DO_SET_LIMIT, 10'd1023, 5'd0,  1'b0, NO_WANT},
      '{DO_ALLOC,     10'd0,    5'd0,  1'b0, NO_WANT},
      '{DO_ALLOC,     10'd0,    5'd0,  1'b0, NO_WANT},
      '{DO_FREE,      10'd1,    5'd31, 1'b1, '{STATUS_BAD_FREE, 4'd0, 5'd0, 1'b0, 10'd30}},
      '{DO_FREE,      10'd1,    5'd0,  1'b0, NO_WANT},
      '{DO_ALLOC,     10'd15,   5'd31, 1'b0, NO_WANT}
   };

   paged_buffer_pool_allocator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // effective slot count: zero behaves as one, anything above the maximum clamps
   function automatic int eff_slots();
      if (slots_cfg == 0) return 1;
      if (slots_cfg > MAX_SLOTS) return MAX_SLOTS;
      return slots_cfg;
   endfunction

   function automatic logic [31:0] whole_page();
      int n = eff_slots();
      return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
   endfunction

   // newest partly free page goes to the head of the recency list
   function automatic void link_front(input int pg);
      link_next[pg] = recent_head;
      link_prev[pg] = NUM_PAGES;
      if (recent_head < NUM_PAGES) link_prev[recent_head] = pg;
      recent_head = pg;
   endfunction

   function automatic void unlink(input int pg);
      int pv = link_prev[pg];
      int nx = link_next[pg];
      if (pv < NUM_PAGES) link_next[pv] = nx;
      else recent_head = nx;
      if (nx < NUM_PAGES) link_prev[nx] = pv;
      link_next[pg] = NUM_PAGES;
      link_prev[pg] = NUM_PAGES;
   endfunction

   // advances the shadow pool by one accepted request and returns its response
   function automatic rsp_type pool_step(input action_type act, input int pg_in,
                                         input int bi_in);
      rsp_type     r;
      int          pg;
      int          bit_i;
      logic [31:0] old_bits;
      logic [31:0] new_bits;
      r = '0;
      r.status = STATUS_OK;
      if (act == ACTION_ALLOC) begin
         if (recent_head < NUM_PAGES) begin
            // lowest free slot of the most recently listed page
            pg = recent_head;
            bit_i = 0;
            while (bit_i < 31 && !page_bits[pg][bit_i]) bit_i++;
            page_bits[pg][bit_i] = 1'b0;
            if (spare_count > 0) spare_count--;
            if (page_bits[pg] == '0) unlink(pg);
            r.out_page_slot = PAGE_W'(pg);
            r.out_buffer_index = IDX_W'(bit_i);
         end else begin
            // map the lowest unused page with slot 0 handed out
            pg = 0;
            while (pg < NUM_PAGES && page_live[pg]) pg++;
            if (pg >= NUM_PAGES) begin
               r.status = STATUS_NO_PAGE;
            end else begin
               new_bits = whole_page() & ~32'd1;
               page_live[pg] = 1'b1;
               page_bits[pg] = new_bits;
               spare_count += $countones(new_bits);
               if (new_bits != '0) link_front(pg);
               r.out_page_slot = PAGE_W'(pg);
            end
         end
      end else begin
         pg = pg_in;
         bit_i = bi_in;
         if (!page_live[pg] || bit_i >= eff_slots() || page_bits[pg][bit_i]) begin
            r.status = STATUS_BAD_FREE;
         end else begin
            old_bits = page_bits[pg];
            new_bits = old_bits | (32'd1 << bit_i);
            page_bits[pg] = new_bits;
            spare_count++;
            if (spare_count > keep_limit && new_bits == whole_page()) begin
               // wholly free page beyond the cache limit goes back
               if (old_bits != '0) unlink(pg);
               spare_count -= $countones(new_bits);
               page_bits[pg] = '0;
               page_live[pg] = 1'b0;
               r.page_released = 1'b1;
            end else if (old_bits == '0) begin
               link_front(pg);
            end
         end
      end
      r.free_buffers = COUNT_W'(spare_count);
      return r;
   endfunction

   // picks a buffer currently handed out, so that the free is well formed
   function automatic bit pick_taken(output logic [PAGE_W-1:0] pg,
                                     output logic [IDX_W-1:0] bi);
      int cand_pg [$];
      int cand_bi [$];
      int k;
      pg = '0;
      bi = '0;
      for (int p = 0; p < NUM_PAGES; p++) begin
         for (int b = 0; b < eff_slots(); b++) begin
            if (page_live[p] && !page_bits[p][b]) begin
               cand_pg.push_back(p);
               cand_bi.push_back(b);
            end
         end
      end
      if (cand_pg.size() == 0) return 1'b0;
      k = $urandom_range(cand_pg.size() - 1);
      pg = PAGE_W'(cand_pg[k]);
      bi = IDX_W'(cand_bi[k]);
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [9:0] want,
                                       input logic [9:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // offers one request, idling first at the sender's rate, and records the
   // expected response once the transaction is taken
   task automatic put_request(input action_type act, input logic [PAGE_W-1:0] pg,
                              input logic [IDX_W-1:0] bi, input bit typed,
                              input rsp_type want);
      rsp_type predicted;
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'd0, bi, pg};
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = pool_step(act, pg, bi);
      due_responses.push_back(typed ? want : predicted);
   endtask

   // register writes only once every outstanding response has come back; the
   // trailing idle cycle keeps enable changes of back-to-back writes apart
   task automatic write_csr(input csr_index_type sel, input int value);
      req_tvalid <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (sel == CSR_BUFFERS_PER_PAGE) slots_cfg = value & ((1 << BPP_W) - 1);
      else keep_limit = value & ((1 << LIMIT_W) - 1);
   endtask

   // response side: check each transaction, then choose ready for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (due_responses.size() == 0) begin
            $error("unexpected response: tuser %0d tdata %h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            head_want = due_responses.pop_front();
            check_field("status", 10'(head_want.status), 10'(rsp_tuser));
            check_field("out_page_slot", 10'(head_want.out_page_slot), 10'(rsp_tdata[3:0]));
            check_field("out_buffer_index", 10'(head_want.out_buffer_index),
                        10'(rsp_tdata[8:4]));
            check_field("page_released", 10'(head_want.page_released), 10'(rsp_tdata[9]));
            check_field("free_buffers", head_want.free_buffers, rsp_tdata[19:10]);
         end
      end
      // one long hold-off so the block fills and stalls its request side
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_ask && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // stimulus: directed script, then random segments with varying registers
   initial begin
      action_type          act;
      logic [PAGE_W-1:0]   pg;
      logic [IDX_W-1:0]    bi;
      int                  alloc_pct;
      int                  roll;
      script_row_type      row;
      foreach (page_bits[p]) begin
         page_bits[p] = '0;
         page_live[p] = 1'b0;
         link_next[p] = NUM_PAGES;
         link_prev[p] = NUM_PAGES;
      end
      recent_head = NUM_PAGES;
      spare_count = 0;
      slots_cfg   = BPP_RESET;
      keep_limit  = LIMIT_RESET;
      alloc_pct   = 50;

      reset <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed part runs with no idling on either side
      for (int r = 0; r < SCRIPT_LEN; r++) begin
         row = script_rows[r];
         case (row.kind)
            DO_ALLOC:     put_request(ACTION_ALLOC, row.page_or_value[PAGE_W-1:0], row.index,
                                      row.typed, row.want);
            DO_FREE:      put_request(ACTION_FREE, row.page_or_value[PAGE_W-1:0], row.index,
                                      row.typed, row.want);
            DO_SET_SLOTS: write_csr(CSR_BUFFERS_PER_PAGE, int'(row.page_or_value));
            default:      write_csr(CSR_CACHE_LIMIT, int'(row.page_or_value));
         endcase
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         // register settings: single-slot pages with no cache first, then
         // small pages, full-size pages with a limit of 512, and random picks
         case (seg)
            0: begin
               write_csr(CSR_BUFFERS_PER_PAGE, 1);
               write_csr(CSR_CACHE_LIMIT, 0);
            end
            1: begin
               write_csr(CSR_BUFFERS_PER_PAGE, 3);
               write_csr(CSR_CACHE_LIMIT, 6);
            end
            2: begin
               write_csr(CSR_BUFFERS_PER_PAGE, MAX_SLOTS);
               write_csr(CSR_CACHE_LIMIT, 512);
            end
            3: begin
               write_csr(CSR_BUFFERS_PER_PAGE, 2);
               write_csr(CSR_CACHE_LIMIT, $urandom_range(40));
            end
            4: begin
               write_csr(CSR_BUFFERS_PER_PAGE, $urandom_range(63));
               write_csr(CSR_CACHE_LIMIT, $urandom_range(1023));
            end
            default: begin
               write_csr(CSR_BUFFERS_PER_PAGE, $urandom_range(8, 1));
               write_csr(CSR_CACHE_LIMIT, $urandom_range(64));
            end
         endcase
         // idling: slow receiver, then slow sender, then back to back
         case (seg / 2)
            0: begin
               sender_idle_pct   = 9;
               receiver_idle_pct = 74;
            end
            1: begin
               sender_idle_pct   = 74;
               receiver_idle_pct = 9;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         hold_ask = (seg == 4);

         for (int n = 0; n < SEG_ITEMS; n++) begin
            // allocate bias drifts so the pool both runs dry and drains back
            if (n % 50 == 0) begin
               case ($urandom_range(2))
                  0:       alloc_pct = 25;
                  1:       alloc_pct = 50;
                  default: alloc_pct = 80;
               endcase
            end
            roll = $urandom_range(99);
            pg = PAGE_W'($urandom);
            bi = IDX_W'($urandom);
            if (roll < NOISE_PCT)
               act = ACTION_FREE;
            else if (roll < NOISE_PCT + alloc_pct * (100 - NOISE_PCT) / 100)
               act = ACTION_ALLOC;
            else if (pick_taken(pg, bi))
               act = ACTION_FREE;
            else
               act = ACTION_ALLOC;
            put_request(act, pg, bi, 1'b0, NO_WANT);
         end
      end

      // drain, then let the pipeline settle to catch any stray response
      req_tvalid <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ files.f @@
rtl/pbpa_pkg.sv
rtl/pbpa_list.sv
rtl/pbpa_engine.sv
rtl/paged_buffer_pool_allocator_top.sv
verif/testbench.sv
